>>> hdl/bsks_pkg.sv
// ----------------------------------------------------------------------------
// bsks_pkg
// Shared types and constants of the batched scalar Kalman smoother.
// ----------------------------------------------------------------------------
package bsks_pkg;

  // Field widths
  localparam int ANGLE_W = 17;   // signed Q9.8 angle
  localparam int ERR_W   = 17;   // unsigned Q1.16 error estimate
  localparam int NOISE_W = 16;   // unsigned Q0.16 measurement noise
  localparam int DEN_W   = ERR_W + 1;
  localparam int REM_W   = DEN_W + 1;
  localparam int OP_W    = ANGLE_W + 1;
  localparam int PROD_W  = 2 * OP_W;

  // Divider sequencing: one quotient bit per cycle
  localparam int DIV_STEPS = ERR_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam int BATCH_LENGTH_DEFAULT = 40;

  localparam logic signed [ANGLE_W-1:0] EST_RESET   = 17'sd23040;
  localparam logic        [ERR_W-1:0]   ONE_Q16     = 17'h10000;
  localparam logic        [NOISE_W-1:0] NOISE_RESET = 16'd6554;
  localparam logic        [PROD_W-1:0]  ROUND_HALF  = 36'd32768;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV,
    S_MUL_P,
    S_UPD_P,
    S_MUL_R,
    S_UPD_R,
    S_MUL_E,
    S_UPD_E,
    S_FINISH
  } state_t;

endpackage

>>> hdl/batched_scalar_kalman_smoother.sv
// ----------------------------------------------------------------------------
// batched_scalar_kalman_smoother
// Two-channel scalar Kalman update with one shared error term, reported once
// per batch. A restoring divider and one multiplier are shared under a small
// sequencer.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake              payload
//  -------  ---------  ---------------------  ----------------------------------
//  in       sink       in_valid / in_stall    pitch_sample, roll_sample
//  out      source     out_valid / out_stall  filtered_pitch, filtered_roll
//  cfg      sink       cfg_write              cfg_data (measurement noise)
//
// The first sample of a batch goes straight to the finish state after acceptance.
// Every other sample runs 17 divider steps (one quotient bit each) for the gain,
// then three multiply and round-and-add pairs through the single multiplier,
// then one bookkeeping step in the finish state.
// Reset is synchronous; estimates return to 90 degrees and the error to 1.0.
// The result sits in an output register; only the batch's last sample waits
// in its final cycle if the previous result has still not been taken.

module batched_scalar_kalman_smoother
  import bsks_pkg::*;
#(
  parameter int BATCH_LENGTH = BATCH_LENGTH_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [ANGLE_W-1:0] pitch_sample,
  input  logic signed [ANGLE_W-1:0] roll_sample,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [ANGLE_W-1:0] filtered_pitch,
  output logic signed [ANGLE_W-1:0] filtered_roll,
  input  logic                      cfg_write,
  input  logic        [NOISE_W-1:0] cfg_data
);

  localparam int POS_W = (BATCH_LENGTH > 2) ? $clog2(BATCH_LENGTH) : 1;
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(BATCH_LENGTH - 1);

  state_t state, state_next;

  logic signed [ANGLE_W-1:0] pitch_estimate;
  logic signed [ANGLE_W-1:0] roll_estimate;
  logic        [ERR_W-1:0]   error_estimate;
  logic        [POS_W-1:0]   batch_position;
  logic        [NOISE_W-1:0] measurement_noise;

  logic signed [ANGLE_W-1:0] pitch_hold;
  logic signed [ANGLE_W-1:0] roll_hold;
  logic        [DEN_W-1:0]   den;
  logic        [REM_W-1:0]   rem;
  logic        [ERR_W-1:0]   quot;
  logic        [DIV_CNT_W-1:0] div_cnt;
  logic signed [PROD_W-1:0]  prod;

  logic                      in_accept;
  logic                      is_last;
  logic                      out_free;
  logic                      rem_ge;
  logic        [REM_W-1:0]   rem_diff;
  logic        [ERR_W-1:0]   gain;
  logic        [ERR_W-1:0]   gain_comp;
  logic signed [OP_W-1:0]    mul_a;
  logic signed [OP_W-1:0]    mul_b;
  logic signed [PROD_W-1:0]  prod_next;
  logic signed [PROD_W-1:0]  prod_rnd;
  logic signed [OP_W:0]      delta;
  logic signed [OP_W:0]      pitch_sum;
  logic signed [OP_W:0]      roll_sum;

  assign in_accept = in_valid && !in_stall;
  assign is_last   = (batch_position == POS_LAST);
  assign out_free  = !out_valid || !out_stall;

  // Divider step: compare the running remainder against the denominator.
  assign rem_ge   = (rem >= REM_W'(den));
  assign rem_diff = rem - REM_W'(den);

  // A zero denominator only happens with zero error and zero noise; gain is 0.
  assign gain      = (den == '0) ? '0 : quot;
  assign gain_comp = ONE_Q16 - gain;

  // Shared multiplier operands.
  always_comb begin
    case (state)
      S_MUL_P: begin
        mul_a = OP_W'(pitch_hold) - OP_W'(pitch_estimate);
        mul_b = $signed({1'b0, gain});
      end
      S_MUL_R: begin
        mul_a = OP_W'(roll_hold) - OP_W'(roll_estimate);
        mul_b = $signed({1'b0, gain});
      end
      default: begin
        mul_a = $signed({1'b0, error_estimate});
        mul_b = $signed({1'b0, gain_comp});
      end
    endcase
  end

  assign prod_next = mul_a * mul_b;

  // Round to nearest, ties upward, then drop the 16 fraction bits.
  assign prod_rnd  = prod + $signed(ROUND_HALF);
  assign delta     = prod_rnd[OP_W+16:16];
  assign pitch_sum = (OP_W+1)'(pitch_estimate) + delta;
  assign roll_sum  = (OP_W+1)'(roll_estimate) + delta;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_next = (batch_position == '0) ? S_FINISH : S_DIV;
        end
      end
      S_DIV: begin
        if (div_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_next = S_MUL_P;
        end
      end
      S_MUL_P:  state_next = S_UPD_P;
      S_UPD_P:  state_next = S_MUL_R;
      S_MUL_R:  state_next = S_UPD_R;
      S_UPD_R:  state_next = S_MUL_E;
      S_MUL_E:  state_next = S_UPD_E;
      S_UPD_E:  state_next = S_FINISH;
      S_FINISH: begin
        if (!is_last || out_free) begin
          state_next = S_IDLE;
        end
      end
      default:  state_next = S_IDLE;
    endcase
  end

  // Working registers of the sequencer.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_accept) begin
          pitch_hold <= pitch_sample;
          roll_hold  <= roll_sample;
          den        <= DEN_W'(error_estimate) + DEN_W'(measurement_noise);
          rem        <= REM_W'(error_estimate);
          quot       <= '0;
          div_cnt    <= '0;
        end
      end
      S_DIV: begin
        if (rem_ge) begin
          rem  <= {rem_diff[REM_W-2:0], 1'b0};
          quot <= {quot[ERR_W-2:0], 1'b1};
        end else begin
          rem  <= {rem[REM_W-2:0], 1'b0};
          quot <= {quot[ERR_W-2:0], 1'b0};
        end
        div_cnt <= div_cnt + 1'b1;
      end
      S_MUL_P, S_MUL_R, S_MUL_E: begin
        prod <= prod_next;
      end
      default: begin
      end
    endcase
  end

  // Filter state, configuration and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      pitch_estimate    <= EST_RESET;
      roll_estimate     <= EST_RESET;
      error_estimate    <= ONE_Q16;
      batch_position    <= '0;
      measurement_noise <= NOISE_RESET;
      out_valid         <= 1'b0;
    end else begin
      if (cfg_write) begin
        measurement_noise <= cfg_data;
      end
      // A taken result is dropped unless the next one is loaded in its place.
      if (out_valid && !out_stall && !(state == S_FINISH && is_last)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_UPD_P: pitch_estimate <= pitch_sum[ANGLE_W-1:0];
        S_UPD_R: roll_estimate  <= roll_sum[ANGLE_W-1:0];
        S_UPD_E: error_estimate <= prod_rnd[ERR_W+15:16];
        S_FINISH: begin
          if (!is_last) begin
            batch_position <= batch_position + 1'b1;
          end else if (out_free) begin
            filtered_pitch <= pitch_estimate;
            filtered_roll  <= roll_estimate;
            out_valid      <= 1'b1;
            error_estimate <= ONE_Q16;
            batch_position <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // The error term is a shrinking product of factors no larger than one.
  a_err_bounded: assert property (@(posedge clk) disable iff (rst)
    error_estimate <= ONE_Q16)
    else $error("error estimate above 1.0");

  // The divider result never exceeds a gain of 1.0.
  a_gain_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL_P) |-> (gain <= ONE_Q16))
    else $error("gain above 1.0");

  // The first sample of a batch skips the update sequence.
  a_skip_first: assert property (@(posedge clk) disable iff (rst)
    (in_accept && batch_position == '0) |=> (state == S_FINISH))
    else $error("first sample of batch was not skipped");

  // A new result appears only together with the batch restart.
  a_result_restart: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> (batch_position == '0 && error_estimate == ONE_Q16))
    else $error("result without batch restart");

endmodule
